### rtl/ordered_list_append_delete_top_assert.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Concurrent assertion shorthands used by the ordered list top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OLAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list assertion failed");
`define OLAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list assertion failed");
`else
`define OLAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLAD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/olad_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Request and status codes, the default capacity and the result type.
// ----------------------------------------------------------------------------
package olad_pkg;

    localparam int OLAD_CAPACITY = 16;
    localparam int DATA_W        = 32;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_EMPTY         = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
    localparam logic [2:0] ST_FIRST_REFUSED = 3'd3;
    localparam logic [2:0] ST_LAST_REFUSED  = 3'd4;
    localparam logic [2:0] ST_FULL          = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] item_value;
        logic [2:0]               status;
        logic                     last;
    } t_result;

endpackage

### rtl/olad_mem.sv
// ----------------------------------------------------------------------------
// Ordered list entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module olad_mem
    import olad_pkg::*;
#(
    parameter int DEPTH = OLAD_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/olad_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list sequencer
// Runs append, search, gap closing and dump over the entry memory.
// ----------------------------------------------------------------------------
module olad_ctrl
    import olad_pkg::*;
#(
    parameter int CAPACITY = OLAD_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_req_type,
    input  logic signed [DATA_W-1:0]      i_value,
    output logic                          o_busy,
    input  logic                          i_out_free,
    output logic                          o_emit,
    output t_result                       o_res,
    output logic [$clog2(CAPACITY+1)-1:0] o_fill_count,
    output logic                          o_we,
    output logic [$clog2(CAPACITY)-1:0]   o_waddr,
    output logic [DATA_W-1:0]             o_wdata,
    output logic                          o_re,
    output logic [$clog2(CAPACITY)-1:0]   o_raddr,
    input  logic [DATA_W-1:0]             i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EMIT   = 3'd1;
    localparam logic [2:0] S_SR_RD  = 3'd2;
    localparam logic [2:0] S_SR_CMP = 3'd3;
    localparam logic [2:0] S_SH_RD  = 3'd4;
    localparam logic [2:0] S_SH_WR  = 3'd5;
    localparam logic [2:0] S_DP_RD  = 3'd6;
    localparam logic [2:0] S_DP_OUT = 3'd7;

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [2:0]               r_status, n_status;
    logic                     w_idx_last;

    assign w_idx_last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_val    = r_val;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = r_val;
        o_re     = 1'b0;
        o_raddr  = r_idx;
        o_emit   = 1'b0;
        o_res.item_value = r_val;
        o_res.status     = r_status;
        o_res.last       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val = i_value;
                    n_idx = '0;
                    case (i_req_type)
                        REQ_APPEND: begin
                            n_state = S_EMIT;
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we     = 1'b1;
                                o_waddr  = r_count[AW-1:0];
                                o_wdata  = i_value;
                                n_count  = r_count + CW'(1);
                                n_status = ST_OK;
                            end
                        end
                        REQ_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_SR_RD;
                            end
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_DP_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SR_RD: begin
                o_re    = 1'b1;
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                if (i_rdata == r_val) begin
                    if (r_count == CW'(1)) begin
                        n_count  = '0;
                        n_status = ST_OK;
                        n_state  = S_EMIT;
                    end else if (r_idx == '0) begin
                        n_status = ST_FIRST_REFUSED;
                        n_state  = S_EMIT;
                    end else if (w_idx_last) begin
                        n_status = ST_LAST_REFUSED;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end else if (w_idx_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_EMIT;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SR_RD;
                end
            end
            S_SH_RD: begin
                if (w_idx_last) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_idx + AW'(1);
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = r_idx + AW'(1);
                n_state = S_SH_RD;
            end
            S_DP_RD: begin
                o_re    = 1'b1;
                n_state = S_DP_OUT;
            end
            S_DP_OUT: begin
                o_res.item_value = i_rdata;
                o_res.status     = ST_OK;
                o_res.last       = w_idx_last;
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (w_idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_DP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_status <= n_status;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_fill_count = r_count;

endmodule

### rtl/ordered_list_append_delete_top.sv
// ----------------------------------------------------------------------------
// Ordered list with append, delete and dump
// Insertion-ordered list of signed 32-bit values held in one memory.
// ----------------------------------------------------------------------------
// An append writes its value at the tail and then hands its item to the
// output register. A delete reads the list from the head one entry at a time
// until it finds the value, and a delete in the middle then moves every entry
// behind it up one place, each by a memory read and a write. A dump reads the
// entries from the head and emits them in order, CAPACITY items at most,
// waiting while the output is stalled. The entry memory registers its read
// data, which arrive in the cycle after the address. A new request is taken
// once the previous one has handed its last item to the output register.
`include "ordered_list_append_delete_top_assert.svh"

module ordered_list_append_delete_top
    import olad_pkg::*;
#(
    parameter int CAPACITY = OLAD_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_item_value,
    output logic [2:0]               o_status,
    output logic                     o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    logic              w_busy;
    logic              w_accept;
    logic              w_full_append;
    logic              w_out_free;
    logic              w_emit;
    t_result           w_res;
    logic [CW-1:0]     w_fill_count;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic              r_out_valid;
    t_result           r_out;

    assign w_accept      = i_valid && !w_busy;
    assign w_full_append = w_accept && (i_req_type == REQ_APPEND)
                           && (w_fill_count == CW'(CAPACITY));
    assign w_out_free    = !r_out_valid || !i_stall;

    olad_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_busy       (w_busy),
        .i_out_free   (w_out_free),
        .o_emit       (w_emit),
        .o_res        (w_res),
        .o_fill_count (w_fill_count),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata)
    );

    olad_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_stall      = w_busy;
    assign o_valid      = r_out_valid;
    assign o_item_value = r_out.item_value;
    assign o_status     = r_out.status;
    assign o_last       = r_out.last;

    `OLAD_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, w_emit, w_out_free)
    `OLAD_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, w_fill_count <= CW'(CAPACITY))
    `OLAD_ASSERT_NXT(a_full_keeps, i_clk, i_rst_n, w_full_append, $stable(w_fill_count))
    `OLAD_ASSERT_NXT(a_out_drain, i_clk, i_rst_n, r_out_valid && !i_stall && !w_emit, !r_out_valid)

endmodule
